[rtl/prc_pkg.sv]
// Package: constants, types and the arctangent table of the polar/rectangular converter.
`default_nettype none
package prc_pkg;

	// Field widths of the request and result channels.
	localparam int OPW  = 16;
	localparam int RAW  = 17;
	localparam int RBW  = 16;

	// Internal number formats.
	localparam int GUARD_BITS      = 14;
	localparam int ZSCALE_BITS     = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int DW              = 32;   // x/y datapath width
	localparam int ZW              = 26;   // angle accumulator width, 1/65536 degree
	localparam int TW              = OPW + 1;   // wrapped input angle width
	localparam int TABLE_LEN       = 24;
	localparam int CORDIC_STEPS_DEF = 16;

	// Gain compensation, Q30, and the rounding that follows it.
	localparam int GAINW       = 31;
	localparam int PW          = DW + GAINW;
	localparam int ROUND_SHIFT = 30 + GUARD_BITS;
	localparam int RW          = PW - ROUND_SHIFT;
	localparam int ZSHIFT      = ZSCALE_BITS - ANGLE_FRAC_BITS;
	localparam int AW          = ZW - ZSHIFT;

	localparam logic signed [GAINW-1:0] GAIN_Q30    = GAINW'(652032874);
	localparam logic signed [ZW-1:0]    QUARTER_Z   = ZW'(90 * 65536);
	localparam logic signed [TW-1:0]    HALF_TURN   = TW'(180 << ANGLE_FRAC_BITS);
	localparam logic signed [TW-1:0]    FULL_TURN   = TW'(360 << ANGLE_FRAC_BITS);
	localparam int                      MAG_MAX     = 46341;

	typedef enum logic {
		REQ_TO_POLAR = 1'b0,
		REQ_TO_RECT  = 1'b1
	} req_kind_t;

	// One item in flight through the rotation stages.
	typedef struct packed {
		logic                 polar;
		logic                 origin;
		logic signed [DW-1:0] cx;
		logic signed [DW-1:0] cy;
		logic signed [ZW-1:0] z;
	} cordic_t;

	// atan(2^-i) in 1/65536 degree, rounded to nearest.
	localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
		ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945),
		ZW'(234379),  ZW'(117304),  ZW'(58666),  ZW'(29335),
		ZW'(14668),   ZW'(7334),    ZW'(3667),   ZW'(1833),
		ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115),
		ZW'(57),      ZW'(29),      ZW'(14),     ZW'(7),
		ZW'(4),       ZW'(2),       ZW'(1),      ZW'(0)
	};

endpackage
`default_nettype wire

[rtl/prc_req_if.sv]
// Interface: request channel of the converter (conversion kind and two operands).
`default_nettype none
interface prc_req_if;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic signed [15:0] operand_a;
	logic signed [15:0] operand_b;

	modport source (output valid, output req_type, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input req_type, input operand_a, input operand_b,
		output ready);
endinterface
`default_nettype wire

[rtl/prc_res_if.sv]
// Interface: result channel of the converter (two result fields).
`default_nettype none
interface prc_res_if;
	logic              valid;
	logic              ready;
	logic signed [16:0] result_a;
	logic signed [15:0] result_b;

	modport source (output valid, output result_a, output result_b, input ready);
	modport sink (input valid, input result_a, input result_b, output ready);
endinterface
`default_nettype wire

[rtl/prc_pre.sv]
// Input stage: scales operands, wraps the angle and applies the quarter-turn pre-rotation.
`default_nettype none
module prc_pre (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic                       req_type,
	input  wire logic signed [prc_pkg::OPW-1:0] operand_a,
	input  wire logic signed [prc_pkg::OPW-1:0] operand_b,
	output logic                            out_valid,
	output prc_pkg::cordic_t                out_data
);
	import prc_pkg::*;

	logic                 valid_s1;
	cordic_t              data_s1;
	cordic_t              nxt;
	logic signed [DW-1:0] ax;
	logic signed [DW-1:0] bx;
	logic signed [TW-1:0] t;
	logic signed [ZW-1:0] zt;

	always_comb begin
		ax  = DW'(operand_a) <<< GUARD_BITS;
		bx  = DW'(operand_b) <<< GUARD_BITS;
		t   = TW'(operand_b);
		zt  = '0;
		nxt = '0;
		if (req_kind_t'(req_type) == REQ_TO_POLAR) begin
			nxt.polar  = 1'b1;
			nxt.origin = (operand_a == '0) && (operand_b == '0);
			if (ax < 0) begin
				if (bx >= 0) begin
					nxt.cx = bx;
					nxt.cy = -ax;
					nxt.z  = QUARTER_Z;
				end else begin
					nxt.cx = -bx;
					nxt.cy = ax;
					nxt.z  = -QUARTER_Z;
				end
			end else begin
				nxt.cx = ax;
				nxt.cy = bx;
			end
		end else begin
			// Bring the angle into (-180, +180] degrees.
			if (t > HALF_TURN) begin
				t = t - FULL_TURN;
			end else if (t <= -HALF_TURN) begin
				t = t + FULL_TURN;
			end
			zt = ZW'(t) <<< ZSHIFT;
			if (zt > QUARTER_Z) begin
				nxt.cy = ax;
				nxt.z  = zt - QUARTER_Z;
			end else if (zt < -QUARTER_Z) begin
				nxt.cy = -ax;
				nxt.z  = zt + QUARTER_Z;
			end else begin
				nxt.cx = ax;
				nxt.z  = zt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

[rtl/prc_stage.sv]
// One registered CORDIC micro-rotation for both vectoring and rotation modes.
`default_nettype none
module prc_stage #(
	parameter int STEP = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire prc_pkg::cordic_t in_data,
	output logic                  out_valid,
	output prc_pkg::cordic_t      out_data
);
	import prc_pkg::*;

	logic                 valid_s1;
	cordic_t              data_s1;
	cordic_t              nxt;
	logic signed [DW-1:0] sx;
	logic signed [DW-1:0] sy;
	logic                 rot_pos;

	always_comb begin
		sx  = in_data.cx >>> STEP;
		sy  = in_data.cy >>> STEP;
		// Vectoring drives y toward zero, rotation drives z toward zero.
		rot_pos = in_data.polar ? in_data.cy[DW-1] : !in_data.z[ZW-1];
		nxt = in_data;
		if (rot_pos) begin
			nxt.cx = in_data.cx - sy;
			nxt.cy = in_data.cy + sx;
			nxt.z  = in_data.z - ATAN_TABLE[STEP];
		end else begin
			nxt.cx = in_data.cx + sy;
			nxt.cy = in_data.cy - sx;
			nxt.z  = in_data.z + ATAN_TABLE[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

[rtl/prc_post.sv]
// Output stages: gain compensation multiply, then rounding, clamping and the result register.
`default_nettype none
module prc_post (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire prc_pkg::cordic_t in_data,
	prc_res_if.source             res
);
	import prc_pkg::*;

	localparam logic signed [PW-1:0] ROUND_BIAS = PW'(64'sd1 <<< (ROUND_SHIFT - 1));
	localparam logic signed [ZW-1:0] ZBIAS      = ZW'(1 << (ZSHIFT - 1));
	localparam logic signed [RW-1:0] S16_MAX    = RW'(32767);
	localparam logic signed [RW-1:0] S16_MIN    = -RW'(32768);
	localparam logic signed [RW-1:0] MAG_TOP    = RW'(MAG_MAX);
	localparam logic signed [AW-1:0] ANG_TOP    = AW'(HALF_TURN);

	logic                 valid_s1;
	logic                 polar_s1;
	logic                 origin_s1;
	logic signed [PW-1:0] pa_s1;
	logic signed [PW-1:0] pb_s1;
	logic signed [ZW-1:0] z_s1;

	logic                  valid_s2;
	logic signed [RAW-1:0] res_a_s2;
	logic signed [RBW-1:0] res_b_s2;

	logic signed [PW-1:0]  sum_a;
	logic signed [PW-1:0]  sum_b;
	logic signed [ZW-1:0]  sum_z;
	logic signed [RW-1:0]  ra;
	logic signed [RW-1:0]  rb;
	logic signed [AW-1:0]  ang;
	logic signed [RAW-1:0] nxt_a;
	logic signed [RBW-1:0] nxt_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			polar_s1  <= in_data.polar;
			origin_s1 <= in_data.origin;
			pa_s1     <= in_data.cx * GAIN_Q30;
			pb_s1     <= in_data.cy * GAIN_Q30;
			z_s1      <= in_data.z;
		end
	end

	always_comb begin
		sum_a = pa_s1 + ROUND_BIAS;
		sum_b = pb_s1 + ROUND_BIAS;
		sum_z = z_s1 + ZBIAS;
		ra    = sum_a[PW-1:ROUND_SHIFT];
		rb    = sum_b[PW-1:ROUND_SHIFT];
		ang   = sum_z[ZW-1:ZSHIFT];
		if (!polar_s1) begin
			if (ra > S16_MAX) begin
				nxt_a = RAW'(S16_MAX);
			end else if (ra < S16_MIN) begin
				nxt_a = RAW'(S16_MIN);
			end else begin
				nxt_a = ra[RAW-1:0];
			end
			if (rb > S16_MAX) begin
				nxt_b = RBW'(S16_MAX);
			end else if (rb < S16_MIN) begin
				nxt_b = RBW'(S16_MIN);
			end else begin
				nxt_b = rb[RBW-1:0];
			end
		end else if (origin_s1) begin
			nxt_a = '0;
			nxt_b = '0;
		end else begin
			if (ra < 0) begin
				nxt_a = '0;
			end else if (ra > MAG_TOP) begin
				nxt_a = RAW'(MAG_TOP);
			end else begin
				nxt_a = ra[RAW-1:0];
			end
			if (ang > ANG_TOP) begin
				nxt_b = RBW'(ANG_TOP);
			end else if (ang < -ANG_TOP) begin
				nxt_b = RBW'(-ANG_TOP);
			end else begin
				nxt_b = ang[RBW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_a_s2 <= nxt_a;
			res_b_s2 <= nxt_b;
		end
	end

	assign res.valid    = valid_s2;
	assign res.result_a = res_a_s2;
	assign res.result_b = res_b_s2;

endmodule
`default_nettype wire

[rtl/polar_rect_converter.sv]
// Top level: pipelined CORDIC converter between rectangular and polar coordinates.
//
//   Channel   Direction   Contents
//   req       in          req_type, operand_a, operand_b
//   res       out         result_a, result_b
//
// Every request passes through CORDIC_STEPS + 3 register stages: one input stage, one
// stage per micro-rotation, one gain multiply stage and one rounding stage that is also
// the output register.
// A new request may enter in every cycle while the result side does not stall, so the sustained rate is one per cycle.
// arst_n clears only the valid bits; the data registers need no reset.
// While a result waits on res, the whole pipeline holds and req.ready is low, so no
// request is accepted until the waiting result leaves; bubbles are not squeezed out.
`default_nettype none
module polar_rect_converter #(
	parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	prc_req_if.sink  req,
	prc_res_if.source res
);
	import prc_pkg::*;

	// The pipeline moves as one when the output register is free or being emptied.
	logic                  adv;
	logic [CORDIC_STEPS:0] vld;
	cordic_t               dat [0:CORDIC_STEPS];

	assign adv       = !res.valid || res.ready;
	assign req.ready = adv;

	// Pre-rotation puts the vector in the right half plane (to polar) or the
	// angle within plus or minus 90 degrees (to rectangular).
	prc_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (req.valid),
		.req_type  (req.req_type),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.out_valid (vld[0]),
		.out_data  (dat[0])
	);

	// One register stage per CORDIC iteration; shift amount and table entry are fixed
	// per stage.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		prc_stage #(
			.STEP (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (vld[i]),
			.in_data   (dat[i]),
			.out_valid (vld[i+1]),
			.out_data  (dat[i+1])
		);
	end

	// Removes the CORDIC gain, rounds to nearest and saturates the results.
	prc_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (vld[CORDIC_STEPS]),
		.in_data  (dat[CORDIC_STEPS]),
		.res      (res)
	);

	// An accepted request is in the input stage on the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld[0])
		else $error("accepted request did not enter the pipeline");

	// A held pipeline neither gains nor loses an item.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld))
		else $error("pipeline valid bits changed during a stall");

	// A held item in the input stage keeps its intermediate values.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && vld[0] |=> $stable(dat[0]))
		else $error("input stage data changed during a stall");

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench of the CORDIC polar/rectangular converter: directed corners, random traffic, checks.
`timescale 1ns / 100ps
module tb_top;
	import prc_pkg::*;

	// The pipeline is one input stage, one stage per micro-rotation, the gain
	// multiply and the output register. The end of the run waits a little more.
	localparam int STEPS         = CORDIC_STEPS_DEF;
	localparam int PIPE_LATENCY  = STEPS + 3;

	// The watchdog counts cycles in which no request and no result is accepted.
	// The longest correct quiet stretch is a drain pause plus a stall burst, well
	// below this.
	localparam int WATCHDOG_LIMIT = 1000;

	// Only the first few mismatches are printed; the rest are only counted.
	localparam int SHOWN_FAILURES = 10;

	// Angle steps of the predictor, atan(2^-i) in 1/65536 degree.
	localparam longint ATAN_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};
	localparam longint GAIN_INV_Q30 = 652032874;
	localparam longint QUARTER_Q16  = 90 * 65536;
	localparam longint HALF_DEG     = 180 * 128;
	localparam longint FULL_DEG     = 360 * 128;
	localparam longint MAG_LIMIT    = 46341;

	// One expected result: magnitude and angle, or saturated x and y.
	typedef struct packed {
		logic signed [RAW-1:0] mag_or_x;
		logic signed [RBW-1:0] ang_or_y;
	} conv_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prc_req_if req_ch();
	prc_res_if res_ch();

	polar_rect_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	// Results that the accepted requests must still produce, oldest first.
	conv_result_t pending_results [$];

	// Idling switches for the request side and the result side.
	bit sender_idles   = 1'b0;
	bit receiver_idles = 1'b0;

	int fail_count   = 0;
	int stall_left   = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Rounds to nearest after a right shift, ties going toward plus infinity.
	// The shift of a signed longint is arithmetic, so it floors.
	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Predicts the one result of a request. Both conversions share the rotation
	// loop; they differ in the pre-rotation and in what steers each step: the
	// sign of y when driving y to zero, the sign of the residual angle otherwise.
	function automatic conv_result_t expected_conversion(input req_kind_t kind,
		input logic signed [OPW-1:0] a, input logic signed [OPW-1:0] b);
		longint cx, cy, z, nx, sx, sy, t, first, second;
		bit ccw;
		conv_result_t res;
		cx = longint'(a) * 16384;
		cy = 0;
		z = 0;
		if (kind == REQ_TO_POLAR) begin
			cy = longint'(b) * 16384;
			// Points left of the y axis are turned by a quarter turn first.
			if (cx < 0) begin
				if (cy >= 0) begin
					nx = cy;
					cy = -cx;
					z = QUARTER_Q16;
				end else begin
					nx = -cy;
					cy = cx;
					z = -QUARTER_Q16;
				end
				cx = nx;
			end
		end else begin
			// The angle wraps modulo a full turn into (-180, +180] degrees.
			t = longint'(b) % FULL_DEG;
			if (t > HALF_DEG)
				t = t - FULL_DEG;
			if (t <= -HALF_DEG)
				t = t + FULL_DEG;
			z = t * 512;
			if (z > QUARTER_Q16) begin
				cy = cx;
				cx = 0;
				z = z - QUARTER_Q16;
			end else if (z < -QUARTER_Q16) begin
				cy = -cx;
				cx = 0;
				z = z + QUARTER_Q16;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			sx = cx >>> i;
			sy = cy >>> i;
			ccw = (kind == REQ_TO_POLAR) ? (cy < 0) : (z >= 0);
			if (ccw) begin
				cx = cx - sy;
				cy = cy + sx;
				z = z - ATAN_Q16[i];
			end else begin
				cx = cx + sy;
				cy = cy - sx;
				z = z + ATAN_Q16[i];
			end
		end
		if (kind == REQ_TO_POLAR) begin
			// The origin has no direction; it gives zero magnitude and zero angle.
			if (a == 0 && b == 0) begin
				first = 0;
				second = 0;
			end else begin
				first = clamp_to(round_half_up(cx * GAIN_INV_Q30, 44), 0, MAG_LIMIT);
				second = clamp_to(round_half_up(z, 9), -HALF_DEG, HALF_DEG);
			end
		end else begin
			first = clamp_to(round_half_up(cx * GAIN_INV_Q30, 44), -32768, 32767);
			second = clamp_to(round_half_up(cy * GAIN_INV_Q30, 44), -32768, 32767);
		end
		res.mag_or_x = RAW'(first);
		res.ang_or_y = RBW'(second);
		return res;
	endfunction

	task automatic flag_failure(input string what);
		if (fail_count < SHOWN_FAILURES)
			$display("FAIL at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Offers one request, with an optional idle burst ahead of it, and records
	// the expected result once the converter has taken it. Valid stays high
	// from one request to the next unless an idle burst lies between them.
	task automatic send_request(input req_kind_t kind, input logic signed [OPW-1:0] a,
		input logic signed [OPW-1:0] b);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(expected_conversion(kind, a, b));
	endtask

	// Random requests. Half of them use the full operand range; the rest aim at
	// small values, the axes, the diagonals and the quadrant borders of the angle.
	task automatic send_random_requests(input int count);
		req_kind_t kind;
		logic signed [OPW-1:0] a, b;
		int quadrant;
		for (int n = 0; n < count; n++) begin
			kind = req_kind_t'(1'($urandom_range(0, 1)));
			a = OPW'($urandom);
			b = OPW'($urandom);
			case ($urandom_range(0, 3))
				2: begin
					a = OPW'(int'($urandom_range(0, 64)) - 32);
					b = OPW'(int'($urandom_range(0, 64)) - 32);
				end
				3: begin
					if (kind == REQ_TO_RECT) begin
						quadrant = int'($urandom_range(0, 4)) - 2;
						b = OPW'(quadrant * 11520 + int'($urandom_range(0, 4)) - 2);
					end else begin
						case ($urandom_range(0, 3))
							0: a = '0;
							1: b = '0;
							2: b = a;
							default: b = -a;
						endcase
					end
				end
				default: ;
			endcase
			send_request(kind, a, b);
		end
	endtask

	// Waits with valid low until every result that is owed has come back.
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Corners of rectangular to polar: the origin, the negative x axis, the
	// largest magnitude that has to be clamped, and each axis at both ends.
	task automatic test_to_polar_corners();
		send_request(REQ_TO_POLAR, 16'sd0, 16'sd0);
		send_request(REQ_TO_POLAR, -16'sd100, 16'sd0);
		send_request(REQ_TO_POLAR, -16'sd32768, 16'sd0);
		send_request(REQ_TO_POLAR, 16'sd32767, 16'sd0);
		send_request(REQ_TO_POLAR, 16'sd0, 16'sd32767);
		send_request(REQ_TO_POLAR, 16'sd0, -16'sd32768);
		send_request(REQ_TO_POLAR, -16'sd32768, -16'sd32768);
		send_request(REQ_TO_POLAR, 16'sd32767, 16'sd32767);
		send_request(REQ_TO_POLAR, -16'sd32768, 16'sd32767);
		send_request(REQ_TO_POLAR, 16'sd1, -16'sd1);
		send_request(REQ_TO_POLAR, -16'sd5, -16'sd7);
	endtask

	// Corners of polar to rectangular: the half and quarter turns, angles that
	// have to wrap, negative magnitudes and results that saturate.
	task automatic test_to_rect_corners();
		send_request(REQ_TO_RECT, 16'sd32767, 16'sd0);
		send_request(REQ_TO_RECT, 16'sd32767, 16'sd11520);
		send_request(REQ_TO_RECT, 16'sd32767, -16'sd11520);
		send_request(REQ_TO_RECT, 16'sd32767, 16'sd23040);
		send_request(REQ_TO_RECT, 16'sd32767, -16'sd23040);
		send_request(REQ_TO_RECT, -16'sd32768, 16'sd23040);
		send_request(REQ_TO_RECT, -16'sd32768, 16'sd0);
		send_request(REQ_TO_RECT, 16'sd1000, 16'sd32767);
		send_request(REQ_TO_RECT, 16'sd1000, -16'sd32768);
		send_request(REQ_TO_RECT, 16'sd0, 16'sd5000);
		send_request(REQ_TO_RECT, 16'sd20000, 16'sd5760);
		send_request(REQ_TO_RECT, -16'sd1, -16'sd5760);
	endtask

	// Random traffic with idle bursts on both sides, in segments that switch
	// the idling on and off so that quiet stretches alternate with busy ones.
	task automatic test_random_with_idling();
		for (int seg = 0; seg < 11; seg++) begin
			sender_idles   = (seg % 3) != 2;
			receiver_idles = (seg % 4) != 3;
			send_random_requests(100);
		end
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	// The sender stops mid-stream until the pipeline has emptied, then resumes.
	task automatic test_pause_for_drain();
		send_random_requests(40);
		wait_for_drain();
		send_random_requests(40);
	endtask

	// The last part runs at full rate: no idling on either side.
	task automatic test_random_full_rate();
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		send_random_requests(750);
	endtask

	// The result side holds ready low in bursts, started at random.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 4);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		conv_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_failure($sformatf("unexpected result a=%0d b=%0d",
					res_ch.result_a, res_ch.result_b));
			end else begin
				want = pending_results.pop_front();
				if (res_ch.result_a !== want.mag_or_x || res_ch.result_b !== want.ang_or_y)
					flag_failure($sformatf("expected a=%0d b=%0d, got a=%0d b=%0d",
						want.mag_or_x, want.ang_or_y, res_ch.result_a, res_ch.result_b));
			end
		end
	end

	// The run ends with a failure when nothing moves for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_TO_POLAR;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;
		res_ch.ready     = 1'b0;

		// Reset is held low from the start and released at a rising edge.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		test_to_polar_corners();
		test_to_rect_corners();
		test_random_with_idling();
		test_pause_for_drain();
		test_random_full_rate();

		// Every owed result must arrive; after that the output has to stay quiet.
		wait_for_drain();
		repeat (PIPE_LATENCY + 4) @(posedge clk);

		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
